// ===== rtl/qch_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qch_pkg
// shared constants for the quad center and height pipeline
// ----------------------------------------------------------------------------
package qch_pkg;

  localparam int unsigned QCH_COORD_W = 16;

endpackage

// ===== rtl/qch_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qch_div
// pipelined signed divider, one quotient bit per stage, rounds to nearest
// with ties away from zero, carries a side payload alongside the operands
// ----------------------------------------------------------------------------
module qch_div #(
  parameter int unsigned NW = 52,
  parameter int unsigned DW = 35,
  parameter int unsigned PW = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic signed [NW-1:0]        in_num,
  input  logic signed [DW-1:0]        in_den,
  input  logic        [PW-1:0]        in_pay,
  output logic                        out_valid,
  output logic signed [((NW > DW) ? NW : DW) + 2:0] out_quo,
  output logic        [PW-1:0]        out_pay
);

  localparam int unsigned MW  = ((NW > DW) ? NW : DW) + 2;
  localparam int unsigned DRW = DW + 1;
  localparam int unsigned RW  = DW + 2;

  logic [NW-1:0]  un;
  logic [DW-1:0]  ud;

  logic           v_r   [0:MW];
  logic [MW-1:0]  nq_r  [0:MW];
  logic           neg_r [0:MW];
  logic [PW-1:0]  pay_r [0:MW];
  logic [RW-1:0]  rem_r [0:MW-1];
  logic [DRW-1:0] d_r   [0:MW-1];

  logic           out_valid_r;
  logic [MW:0]    out_quo_r;
  logic [PW-1:0]  out_pay_r;

  assign un = in_num[NW-1] ? NW'(-in_num) : NW'(in_num);
  assign ud = in_den[DW-1] ? DW'(-in_den) : DW'(in_den);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nq_r[0]  <= MW'({un, 1'b0}) + MW'(ud);
      d_r[0]   <= {ud, 1'b0};
      rem_r[0] <= '0;
      neg_r[0] <= in_num[NW-1] ^ in_den[DW-1];
      pay_r[0] <= in_pay;
    end
  end

  for (genvar k = 1; k <= MW; k++) begin : g_step
    logic [RW-1:0] trial;
    logic          ge;

    assign trial = {rem_r[k-1][RW-2:0], nq_r[k-1][MW-1]};
    assign ge    = trial >= RW'(d_r[k-1]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nq_r[k]  <= {nq_r[k-1][MW-2:0], ge};
        neg_r[k] <= neg_r[k-1];
        pay_r[k] <= pay_r[k-1];
      end
    end

    if (k < MW) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? trial - RW'(d_r[k-1]) : trial;
          d_r[k]   <= d_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_r[MW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_quo_r <= neg_r[MW] ? -{1'b0, nq_r[MW]} : {1'b0, nq_r[MW]};
      out_pay_r <= pay_r[MW];
    end
  end

  assign out_valid = out_valid_r;
  assign out_quo   = out_quo_r;
  assign out_pay   = out_pay_r;

endmodule

// ===== rtl/qch_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qch_front
// diagonal setup: differences, cross products, scaled numerators and the
// corner mean used when the diagonals are parallel
// ----------------------------------------------------------------------------
module qch_front #(
  parameter int unsigned CW = qch_pkg::QCH_COORD_W
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [3:0][CW-1:0]         in_px,
  input  logic [3:0][CW-1:0]         in_py,
  input  logic                       in_present,
  output logic                       out_valid,
  output logic signed [3*CW+3:0]     out_numx,
  output logic signed [3*CW+3:0]     out_numy,
  output logic signed [2*CW+2:0]     out_den,
  output logic [3:0][CW-1:0]         out_px,
  output logic [3:0][CW-1:0]         out_py,
  output logic                       out_present,
  output logic                       out_par,
  output logic [CW-1:0]              out_meanx,
  output logic [CW-1:0]              out_meany
);
  import qch_pkg::*;

  // stage 1
  logic                v1_r, pres1_r;
  logic [3:0][CW-1:0]  px1_r, py1_r;
  // stage 2
  logic                v2_r, pres2_r;
  logic [3:0][CW-1:0]  px2_r, py2_r;
  logic signed [CW:0]  d02x2_r, d02y2_r, d13x2_r, d13y2_r, ex2_r, ey2_r;
  logic signed [CW+1:0] sx2_r, sy2_r;
  // stage 3
  logic                v3_r, pres3_r;
  logic [3:0][CW-1:0]  px3_r, py3_r;
  logic signed [CW:0]  d02x3_r, d02y3_r;
  logic signed [2*CW+1:0] pa3_r, pb3_r, pc3_r, pd3_r;
  logic [CW-1:0]       mx3_r, my3_r;
  // stage 4
  logic                v4_r, pres4_r;
  logic [3:0][CW-1:0]  px4_r, py4_r;
  logic signed [CW:0]  d02x4_r, d02y4_r;
  logic signed [2*CW+2:0] den4_r, num4_r;
  logic [CW-1:0]       mx4_r, my4_r;
  // stage 5
  logic                v5_r, pres5_r, par5_r;
  logic [3:0][CW-1:0]  px5_r, py5_r;
  logic signed [3*CW+3:0] numx5_r, numy5_r;
  logic signed [2*CW+2:0] den5_r;
  logic [CW-1:0]       mx5_r, my5_r;

  logic signed [CW-1:0] p0x, p1x, p2x, p3x, p0y, p1y, p2y, p3y;
  logic [CW+1:0]        magx, magy;
  logic [CW+1:0]        qx, qy;

  assign p0x = px1_r[0];
  assign p1x = px1_r[1];
  assign p2x = px1_r[2];
  assign p3x = px1_r[3];
  assign p0y = py1_r[0];
  assign p1y = py1_r[1];
  assign p2y = py1_r[2];
  assign p3y = py1_r[3];

  assign magx = sx2_r[CW+1] ? (CW+2)'(-sx2_r) : (CW+2)'(sx2_r);
  assign magy = sy2_r[CW+1] ? (CW+2)'(-sy2_r) : (CW+2)'(sy2_r);
  assign qx   = (magx + (CW+2)'(2)) >> 2;
  assign qy   = (magy + (CW+2)'(2)) >> 2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px1_r   <= in_px;
      py1_r   <= in_py;
      pres1_r <= in_present;

      px2_r   <= px1_r;
      py2_r   <= py1_r;
      pres2_r <= pres1_r;
      d02x2_r <= (CW+1)'(p2x) - (CW+1)'(p0x);
      d02y2_r <= (CW+1)'(p2y) - (CW+1)'(p0y);
      d13x2_r <= (CW+1)'(p3x) - (CW+1)'(p1x);
      d13y2_r <= (CW+1)'(p3y) - (CW+1)'(p1y);
      ex2_r   <= (CW+1)'(p1x) - (CW+1)'(p0x);
      ey2_r   <= (CW+1)'(p1y) - (CW+1)'(p0y);
      sx2_r   <= (CW+2)'(p0x) + (CW+2)'(p1x) + (CW+2)'(p2x) + (CW+2)'(p3x);
      sy2_r   <= (CW+2)'(p0y) + (CW+2)'(p1y) + (CW+2)'(p2y) + (CW+2)'(p3y);

      px3_r   <= px2_r;
      py3_r   <= py2_r;
      pres3_r <= pres2_r;
      d02x3_r <= d02x2_r;
      d02y3_r <= d02y2_r;
      pa3_r   <= (2*CW+2)'(d02x2_r) * (2*CW+2)'(d13y2_r);
      pb3_r   <= (2*CW+2)'(d02y2_r) * (2*CW+2)'(d13x2_r);
      pc3_r   <= (2*CW+2)'(ex2_r) * (2*CW+2)'(d13y2_r);
      pd3_r   <= (2*CW+2)'(ey2_r) * (2*CW+2)'(d13x2_r);
      mx3_r   <= sx2_r[CW+1] ? CW'(-qx) : CW'(qx);
      my3_r   <= sy2_r[CW+1] ? CW'(-qy) : CW'(qy);

      px4_r   <= px3_r;
      py4_r   <= py3_r;
      pres4_r <= pres3_r;
      d02x4_r <= d02x3_r;
      d02y4_r <= d02y3_r;
      den4_r  <= (2*CW+3)'(pa3_r) - (2*CW+3)'(pb3_r);
      num4_r  <= (2*CW+3)'(pc3_r) - (2*CW+3)'(pd3_r);
      mx4_r   <= mx3_r;
      my4_r   <= my3_r;

      px5_r   <= px4_r;
      py5_r   <= py4_r;
      pres5_r <= pres4_r;
      par5_r  <= den4_r == '0;
      den5_r  <= (den4_r == '0) ? (2*CW+3)'(1) : den4_r;
      numx5_r <= (3*CW+4)'(num4_r) * (3*CW+4)'(d02x4_r);
      numy5_r <= (3*CW+4)'(num4_r) * (3*CW+4)'(d02y4_r);
      mx5_r   <= mx4_r;
      my5_r   <= my4_r;
    end
  end

  assign out_valid   = v5_r;
  assign out_numx    = numx5_r;
  assign out_numy    = numy5_r;
  assign out_den     = den5_r;
  assign out_px      = px5_r;
  assign out_py      = py5_r;
  assign out_present = pres5_r;
  assign out_par     = par5_r;
  assign out_meanx   = mx5_r;
  assign out_meany   = my5_r;

endmodule

// ===== rtl/quad_center_and_height.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_center_and_height
// center of a tag quad as the crossing of its diagonals, and the height
// between top and bottom edges at the center column
// ----------------------------------------------------------------------------
// One corner set enters every clock cycle and results leave at the same
// rate while out_stall is low. Two bit-serial pipelined dividers run in
// series: the center divider has 3*COORD_WIDTH + 8 stages and the edge
// divider 2*COORD_WIDTH + 6. A stall on the result side holds the whole
// pipeline; the input is stalled only while a finished result is waiting
// and out_stall is high.
module quad_center_and_height #(
  parameter int unsigned COORD_WIDTH = qch_pkg::QCH_COORD_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_corner0_x,
  input  logic signed [COORD_WIDTH-1:0] in_corner0_y,
  input  logic signed [COORD_WIDTH-1:0] in_corner1_x,
  input  logic signed [COORD_WIDTH-1:0] in_corner1_y,
  input  logic signed [COORD_WIDTH-1:0] in_corner2_x,
  input  logic signed [COORD_WIDTH-1:0] in_corner2_y,
  input  logic signed [COORD_WIDTH-1:0] in_corner3_x,
  input  logic signed [COORD_WIDTH-1:0] in_corner3_y,
  input  logic                          in_corners_present,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] out_center_x,
  output logic signed [COORD_WIDTH-1:0] out_center_y,
  output logic        [COORD_WIDTH-1:0] out_tag_height,
  output logic                          out_parallel_diagonals,
  output logic                          out_clipped
);
  import qch_pkg::*;

  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned QCW = 3*CW + 7;
  localparam int unsigned QEW = 2*CW + 5;
  localparam int unsigned PXW = 2*CW;
  localparam int unsigned PYW = 9*CW + 2;
  localparam int unsigned PTW = 4*CW + 5;
  localparam int unsigned PBW = 2*CW + 2;
  localparam int unsigned TW  = 2*CW + 6;
  localparam int unsigned HW  = 2*CW + 7;

  logic en;

  logic                    fv, fpres, fpar;
  logic signed [3*CW+3:0]  fnumx, fnumy;
  logic signed [2*CW+2:0]  fden;
  logic [3:0][CW-1:0]      fpx, fpy, ipx, ipy;
  logic [CW-1:0]           fmx, fmy;

  logic                    dxv, dyv;
  logic signed [QCW-1:0]   qx, qy;
  logic [PXW-1:0]          payx;
  logic [PYW-1:0]          payy;

  // center stage
  logic                    vf_r, presf_r, parf_r, clipf_r;
  logic [3:0][CW-1:0]      pxf_r, pyf_r;
  logic signed [CW-1:0]    cxf_r, cyf_r;
  logic signed [QCW:0]     sumx, sumy;
  logic                    okx, oky;
  logic [3:0][CW-1:0]      cpx, cpy;
  logic signed [CW-1:0]    cp0x, cp0y;

  // edge difference stage
  logic                    vg_r, presg_r, parg_r, clipg_r;
  logic signed [CW-1:0]    cxg_r, cyg_r;
  logic signed [CW:0]      tdxg_r, tdyg_r, txog_r, bdxg_r, bdyg_r, bxog_r;
  logic signed [CW-1:0]    tayg_r, bayg_r;
  logic signed [CW:0]      tsg, bsg;
  logic [CW:0]             tmag, bmag, tq, bq;
  logic signed [CW:0]      tvmg_r, bvmg_r;

  // edge product stage
  logic                    vh_r, presh_r, parh_r, cliph_r;
  logic signed [CW-1:0]    cxh_r, cyh_r, tayh_r, bayh_r;
  logic signed [2*CW+1:0]  tprh_r, bprh_r;
  logic signed [CW:0]      tdnh_r, bdnh_r, tvmh_r, bvmh_r;
  logic                    tverh_r, bverh_r;

  logic                    etv, ebv;
  logic signed [QEW-1:0]   tqo, bqo;
  logic [PTW-1:0]          payt, payto;
  logic [PBW-1:0]          payb, paybo;

  // edge sum stage
  logic                    vi_r, presi_r, pari_r, clipi_r;
  logic signed [CW-1:0]    cxi_r, cyi_r;
  logic signed [TW-1:0]    topi_r, boti_r;
  logic signed [CW-1:0]    etay, ebay;
  logic signed [CW:0]      etvm, ebvm;
  logic                    etver, ebver;

  logic signed [HW-1:0]    hd;
  logic [HW-1:0]           hmag;
  logic                    hok;

  logic                    out_valid_r;
  logic [CW-1:0]           cx_o_r, cy_o_r, h_o_r;
  logic                    par_o_r, clip_o_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  assign ipx = {in_corner3_x, in_corner2_x, in_corner1_x, in_corner0_x};
  assign ipy = {in_corner3_y, in_corner2_y, in_corner1_y, in_corner0_y};

  qch_front #(.CW(CW)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_valid),
    .in_px       (ipx),
    .in_py       (ipy),
    .in_present  (in_corners_present),
    .out_valid   (fv),
    .out_numx    (fnumx),
    .out_numy    (fnumy),
    .out_den     (fden),
    .out_px      (fpx),
    .out_py      (fpy),
    .out_present (fpres),
    .out_par     (fpar),
    .out_meanx   (fmx),
    .out_meany   (fmy)
  );

  assign payx = {fpx[0], fmx};
  assign payy = {fpx, fpy, fmy, fpar, fpres};

  logic [PXW-1:0] payxo;
  logic [PYW-1:0] payyo;

  qch_div #(.NW(3*CW+4), .DW(2*CW+3), .PW(PXW)) u_div_cx (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fv),
    .in_num    (fnumx),
    .in_den    (fden),
    .in_pay    (payx),
    .out_valid (dxv),
    .out_quo   (qx),
    .out_pay   (payxo)
  );

  qch_div #(.NW(3*CW+4), .DW(2*CW+3), .PW(PYW)) u_div_cy (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fv),
    .in_num    (fnumy),
    .in_den    (fden),
    .in_pay    (payy),
    .out_valid (dyv),
    .out_quo   (qy),
    .out_pay   (payyo)
  );

  // center saturation
  assign cpx  = payyo[PYW-1 -: 4*CW];
  assign cpy  = payyo[PYW-4*CW-1 -: 4*CW];
  assign cp0x = payxo[PXW-1 -: CW];
  assign cp0y = cpy[0];
  assign sumx = payyo[1] ? (QCW+1)'($signed(payxo[CW-1:0]))
                         : (QCW+1)'(cp0x) + (QCW+1)'(qx);
  assign sumy = payyo[1] ? (QCW+1)'($signed(payyo[CW+1:2]))
                         : (QCW+1)'(cp0y) + (QCW+1)'(qy);
  assign okx  = (sumx[QCW:CW-1] == '0) || (sumx[QCW:CW-1] == '1);
  assign oky  = (sumy[QCW:CW-1] == '0) || (sumy[QCW:CW-1] == '1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
      vg_r <= 1'b0;
      vh_r <= 1'b0;
      vi_r <= 1'b0;
    end else if (en) begin
      vf_r <= dxv && dyv;
      vg_r <= vf_r;
      vh_r <= vg_r;
      vi_r <= etv && ebv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pxf_r   <= cpx;
      pyf_r   <= cpy;
      presf_r <= payyo[0];
      parf_r  <= payyo[1];
      clipf_r <= !okx || !oky;
      cxf_r   <= okx ? CW'(sumx) : {sumx[QCW], {(CW-1){!sumx[QCW]}}};
      cyf_r   <= oky ? CW'(sumy) : {sumy[QCW], {(CW-1){!sumy[QCW]}}};
    end
  end

  // edge differences, top edge 0-1 and bottom edge 3-2
  assign tsg  = (CW+1)'($signed(pyf_r[0])) + (CW+1)'($signed(pyf_r[1]));
  assign bsg  = (CW+1)'($signed(pyf_r[3])) + (CW+1)'($signed(pyf_r[2]));
  assign tmag = tsg[CW] ? (CW+1)'(-tsg) : (CW+1)'(tsg);
  assign bmag = bsg[CW] ? (CW+1)'(-bsg) : (CW+1)'(bsg);
  assign tq   = (tmag + (CW+1)'(1)) >> 1;
  assign bq   = (bmag + (CW+1)'(1)) >> 1;

  always_ff @(posedge clk) begin
    if (en) begin
      presg_r <= presf_r;
      parg_r  <= parf_r;
      clipg_r <= clipf_r;
      cxg_r   <= cxf_r;
      cyg_r   <= cyf_r;
      tdxg_r  <= (CW+1)'($signed(pxf_r[1])) - (CW+1)'($signed(pxf_r[0]));
      tdyg_r  <= (CW+1)'($signed(pyf_r[1])) - (CW+1)'($signed(pyf_r[0]));
      txog_r  <= (CW+1)'(cxf_r) - (CW+1)'($signed(pxf_r[0]));
      bdxg_r  <= (CW+1)'($signed(pxf_r[2])) - (CW+1)'($signed(pxf_r[3]));
      bdyg_r  <= (CW+1)'($signed(pyf_r[2])) - (CW+1)'($signed(pyf_r[3]));
      bxog_r  <= (CW+1)'(cxf_r) - (CW+1)'($signed(pxf_r[3]));
      tayg_r  <= pyf_r[0];
      bayg_r  <= pyf_r[3];
      tvmg_r  <= tsg[CW] ? -tq : tq;
      bvmg_r  <= bsg[CW] ? -bq : bq;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      presh_r <= presg_r;
      parh_r  <= parg_r;
      cliph_r <= clipg_r;
      cxh_r   <= cxg_r;
      cyh_r   <= cyg_r;
      tayh_r  <= tayg_r;
      bayh_r  <= bayg_r;
      tvmh_r  <= tvmg_r;
      bvmh_r  <= bvmg_r;
      tverh_r <= tdxg_r == '0;
      bverh_r <= bdxg_r == '0;
      tdnh_r  <= (tdxg_r == '0) ? (CW+1)'(1) : tdxg_r;
      bdnh_r  <= (bdxg_r == '0) ? (CW+1)'(1) : bdxg_r;
      tprh_r  <= (2*CW+2)'(txog_r) * (2*CW+2)'(tdyg_r);
      bprh_r  <= (2*CW+2)'(bxog_r) * (2*CW+2)'(bdyg_r);
    end
  end

  assign payt = {cxh_r, cyh_r, tayh_r, tvmh_r, tverh_r, presh_r, parh_r, cliph_r};
  assign payb = {bayh_r, bvmh_r, bverh_r};

  qch_div #(.NW(2*CW+2), .DW(CW+1), .PW(PTW)) u_div_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vh_r),
    .in_num    (tprh_r),
    .in_den    (tdnh_r),
    .in_pay    (payt),
    .out_valid (etv),
    .out_quo   (tqo),
    .out_pay   (payto)
  );

  qch_div #(.NW(2*CW+2), .DW(CW+1), .PW(PBW)) u_div_bot (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vh_r),
    .in_num    (bprh_r),
    .in_den    (bdnh_r),
    .in_pay    (payb),
    .out_valid (ebv),
    .out_quo   (bqo),
    .out_pay   (paybo)
  );

  assign etay  = payto[PTW-2*CW-1 -: CW];
  assign etvm  = payto[CW+4 -: CW+1];
  assign etver = payto[3];
  assign ebay  = paybo[PBW-1 -: CW];
  assign ebvm  = paybo[CW+1 -: CW+1];
  assign ebver = paybo[0];

  always_ff @(posedge clk) begin
    if (en) begin
      cxi_r   <= payto[PTW-1 -: CW];
      cyi_r   <= payto[PTW-CW-1 -: CW];
      presi_r <= payto[2];
      pari_r  <= payto[1];
      clipi_r <= payto[0];
      topi_r  <= etver ? TW'(etvm) : TW'(etay) + TW'(tqo);
      boti_r  <= ebver ? TW'(ebvm) : TW'(ebay) + TW'(bqo);
    end
  end

  // height and output register
  assign hd   = HW'(boti_r) - HW'(topi_r);
  assign hmag = hd[HW-1] ? HW'(-hd) : HW'(hd);
  assign hok  = hmag[HW-1:CW] == '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vi_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx_o_r   <= presi_r ? cxi_r : '0;
      cy_o_r   <= presi_r ? cyi_r : '0;
      h_o_r    <= !presi_r ? '0 : (hok ? CW'(hmag) : '1);
      par_o_r  <= presi_r && pari_r;
      clip_o_r <= presi_r && (clipi_r || !hok);
    end
  end

  assign out_valid              = out_valid_r;
  assign out_center_x           = cx_o_r;
  assign out_center_y           = cy_o_r;
  assign out_tag_height         = h_o_r;
  assign out_parallel_diagonals = par_o_r;
  assign out_clipped            = clip_o_r;

endmodule
